>>> hdl/mecodo_pkg.sv
// ----------------------------------------------------------------------------
// mecodo_pkg: shared types and constants of the mecanum odometry unit
// Microcode format, sequencer control bundle, register indexes and the
// fixed-point widths of the kinematics datapath.
// ----------------------------------------------------------------------------
package mecodo_pkg;

  // wheel speed width and derived datapath widths
  localparam int SPEED_WIDTH = 16;
  localparam int SUM_W       = SPEED_WIDTH + 2;
  localparam int MUL_A_W     = (SUM_W > 16) ? SUM_W : 16;
  localparam int MUL_B_W     = 17;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int IN_DATA_W   = ((4 * SPEED_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_W  = 128;

  // heading constants in Q2.13
  localparam int HEAD_PI     = 25736;
  localparam int HEAD_TWO_PI = 51472;

  // heading reduction: offset by 2^(MOD_STEPS-1) turns, then restoring steps
  localparam int MOD_STEPS   = 6;
  localparam int LOOP_W      = $clog2(MOD_STEPS);
  localparam int REM_W       = 22;

  // register reset values
  localparam logic [15:0] LIN_RESET  = 16'd1638;
  localparam logic [15:0] ROT_RESET  = 16'd2048;
  localparam logic [15:0] TICK_RESET = 16'd655;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_LIN  = 2'd0,
    REG_ROT  = 2'd1,
    REG_TICK = 2'd2
  } cfg_reg_t;

  // multiplier operand selection
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_SX_LIN,
    MUL_SY_LIN,
    MUL_SW_ROT,
    MUL_VX_TP,
    MUL_VY_TP,
    MUL_WZ_TP
  } mul_op_t;

  // writeback of the product register
  typedef enum logic [3:0] {
    WB_NONE,
    WB_VX,
    WB_VY,
    WB_WZ,
    WB_PX,
    WB_PY,
    WB_HEAD,
    WB_MOD,
    WB_DONE
  } wb_op_t;

  // sequencing of the step counter
  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_LOOP,
    JMP_END
  } jmp_t;

  localparam int PC_W = 4;

  typedef struct packed {
    mul_op_t mul;
    wb_op_t  wb;
    jmp_t    jmp;
    logic    load_loop;
  } ucode_t;

  typedef struct packed {
    logic              active;
    ucode_t            word;
    logic [LOOP_W-1:0] loop_cnt;
  } seq_ctrl_t;

  // microprogram: one control word per step
  function automatic ucode_t micro_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      4'd0:    w = '{MUL_SX_LIN, WB_NONE, JMP_NEXT, 1'b0};
      4'd1:    w = '{MUL_SY_LIN, WB_VX,   JMP_NEXT, 1'b0};
      4'd2:    w = '{MUL_SW_ROT, WB_VY,   JMP_NEXT, 1'b0};
      4'd3:    w = '{MUL_VX_TP,  WB_WZ,   JMP_NEXT, 1'b0};
      4'd4:    w = '{MUL_VY_TP,  WB_PX,   JMP_NEXT, 1'b0};
      4'd5:    w = '{MUL_WZ_TP,  WB_PY,   JMP_NEXT, 1'b0};
      4'd6:    w = '{MUL_NONE,   WB_HEAD, JMP_NEXT, 1'b1};
      4'd7:    w = '{MUL_NONE,   WB_MOD,  JMP_LOOP, 1'b0};
      4'd8:    w = '{MUL_NONE,   WB_DONE, JMP_END,  1'b0};
      default: w = '{MUL_NONE,   WB_NONE, JMP_END,  1'b0};
    endcase
    return w;
  endfunction

endpackage

>>> hdl/mecanum_odometry_unit.sv
// ----------------------------------------------------------------------------
// mecanum_odometry_unit: mecanum forward kinematics and pose integration
// Per tick: body velocities from four wheel speeds, then x, y and heading
// integration with saturation and a 2*pi heading wrap.
// ----------------------------------------------------------------------------
// One item is one control tick. It is taken only while no tick is in work, and
// the next tick can be taken in the cycle after the result is handed to the
// output register. The microprogram makes six passes through a single shared
// 18x17 multiplier and six restoring steps of the heading modulo reduction.
// A result that is not taken holds the last microprogram step. The
// configuration registers must be written only while the block is idle.
module mecanum_odometry_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [mecodo_pkg::IN_DATA_W-1:0]  in_tdata,  // wheel_fr, wheel_fl, wheel_rr, wheel_rl
  input  logic                              in_tuser,  // clear_pose
  // result channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mecodo_pkg::OUT_DATA_W-1:0] out_tdata, // vel_x, vel_y, yaw_rate, pos_x, pos_y, heading
  // configuration
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_addr,
  input  logic [15:0]                       cfg_wdata
);

  localparam int SW     = mecodo_pkg::SPEED_WIDTH;
  localparam int SUM_W  = mecodo_pkg::SUM_W;
  localparam int MA_W   = mecodo_pkg::MUL_A_W;
  localparam int MB_W   = mecodo_pkg::MUL_B_W;
  localparam int PROD_W = mecodo_pkg::PROD_W;
  localparam int VS_W   = PROD_W - 16;
  localparam int YS_W   = PROD_W - 12;
  localparam int PI_W   = PROD_W - 8;
  localparam int HI_W   = PROD_W - 11;
  localparam int HS_W   = HI_W + 2;
  localparam int REM_W  = mecodo_pkg::REM_W;
  localparam int POS_W  = 33;

  mecodo_pkg::seq_ctrl_t ctrl;

  logic [15:0]              lin_r, rot_r, tick_r;
  logic signed [SUM_W-1:0]  sx_r, sy_r, sw_r;
  logic signed [15:0]       vx_r, vy_r, wz_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [31:0]       acc_x_r, acc_y_r;
  logic signed [15:0]       acc_h_r;
  logic [REM_W-1:0]         rem_r;
  logic [mecodo_pkg::OUT_DATA_W-1:0] out_data_r;
  logic                     out_valid_r;

  logic                     in_acc, hold, fire;
  logic signed [SUM_W-1:0]  fr, fl, rr, rl;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [PROD_W-1:0] rnd_v, rnd_y, rnd_p, rnd_h;
  logic signed [VS_W-1:0]   vel_sh;
  logic signed [YS_W-1:0]   yaw_sh;
  logic signed [PI_W-1:0]   pos_inc;
  logic signed [HI_W-1:0]   head_inc;
  logic signed [15:0]       vel_sat, yaw_sat;
  logic signed [31:0]       pos_base, pos_sat;
  logic signed [POS_W-1:0]  pos_sum;
  logic signed [HS_W-1:0]   head_sum;
  logic [REM_W-1:0]         mod_sub;
  logic signed [15:0]       head_fin;

  // handshake
  assign in_tready  = !ctrl.active;
  assign in_acc     = in_tvalid && in_tready;
  assign hold       = out_valid_r && !out_tready;
  assign fire       = ctrl.active && (ctrl.word.jmp == mecodo_pkg::JMP_END) && !hold;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  mecodo_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc),
    .hold  (hold),
    .ctrl  (ctrl)
  );

  // wheel speeds, sign extended for the kinematic sums
  assign fr = SUM_W'($signed(in_tdata[SW-1:0]));
  assign fl = SUM_W'($signed(in_tdata[2*SW-1:SW]));
  assign rr = SUM_W'($signed(in_tdata[3*SW-1:2*SW]));
  assign rl = SUM_W'($signed(in_tdata[4*SW-1:3*SW]));

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctrl.word.mul)
      mecodo_pkg::MUL_SX_LIN: begin
        mul_a = MA_W'(sx_r);
        mul_b = {1'b0, lin_r};
      end
      mecodo_pkg::MUL_SY_LIN: begin
        mul_a = MA_W'(sy_r);
        mul_b = {1'b0, lin_r};
      end
      mecodo_pkg::MUL_SW_ROT: begin
        mul_a = MA_W'(sw_r);
        mul_b = {1'b0, rot_r};
      end
      mecodo_pkg::MUL_VX_TP: begin
        mul_a = MA_W'(vx_r);
        mul_b = {1'b0, tick_r};
      end
      mecodo_pkg::MUL_VY_TP: begin
        mul_a = MA_W'(vy_r);
        mul_b = {1'b0, tick_r};
      end
      mecodo_pkg::MUL_WZ_TP: begin
        mul_a = MA_W'(wz_r);
        mul_b = {1'b0, tick_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // round half up: add half an lsb, then arithmetic shift
  assign rnd_v    = prod_r + PROD_W'(32768);
  assign rnd_y    = prod_r + PROD_W'(2048);
  assign rnd_p    = prod_r + PROD_W'(128);
  assign rnd_h    = prod_r + PROD_W'(1024);
  assign vel_sh   = rnd_v[PROD_W-1:16];
  assign yaw_sh   = rnd_y[PROD_W-1:12];
  assign pos_inc  = rnd_p[PROD_W-1:8];
  assign head_inc = rnd_h[PROD_W-1:11];

  // velocity saturation to 16 bits
  always_comb begin
    if (vel_sh[VS_W-1:15] == '0 || vel_sh[VS_W-1:15] == '1) begin
      vel_sat = vel_sh[15:0];
    end else begin
      vel_sat = vel_sh[VS_W-1] ? 16'sh8000 : 16'sh7fff;
    end
    if (yaw_sh[YS_W-1:15] == '0 || yaw_sh[YS_W-1:15] == '1) begin
      yaw_sat = yaw_sh[15:0];
    end else begin
      yaw_sat = yaw_sh[YS_W-1] ? 16'sh8000 : 16'sh7fff;
    end
  end

  // position accumulate with saturation
  assign pos_base = (ctrl.word.wb == mecodo_pkg::WB_PY) ? acc_y_r : acc_x_r;
  assign pos_sum  = POS_W'(pos_base) + POS_W'(pos_inc);
  always_comb begin
    if (pos_sum[POS_W-1] == pos_sum[31]) begin
      pos_sat = pos_sum[31:0];
    end else begin
      pos_sat = pos_sum[POS_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
  end

  // heading: offset so the sum is never negative, then reduce by 2*pi
  assign head_sum = HS_W'(acc_h_r) + HS_W'(head_inc) + HS_W'(mecodo_pkg::HEAD_PI)
                  + HS_W'(mecodo_pkg::HEAD_TWO_PI * (2 ** (mecodo_pkg::MOD_STEPS - 1)));
  assign mod_sub  = REM_W'(mecodo_pkg::HEAD_TWO_PI) << ctrl.loop_cnt;
  assign head_fin = 16'(rem_r) - 16'(mecodo_pkg::HEAD_PI);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_r  <= mecodo_pkg::LIN_RESET;
      rot_r  <= mecodo_pkg::ROT_RESET;
      tick_r <= mecodo_pkg::TICK_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        mecodo_pkg::REG_LIN:  lin_r  <= cfg_wdata;
        mecodo_pkg::REG_ROT:  rot_r  <= cfg_wdata;
        mecodo_pkg::REG_TICK: tick_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pose state: cleared on request at acceptance, updated by the program
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_x_r <= '0;
      acc_y_r <= '0;
      acc_h_r <= '0;
    end else if (in_acc) begin
      if (in_tuser) begin
        acc_x_r <= '0;
        acc_y_r <= '0;
        acc_h_r <= '0;
      end
    end else if (ctrl.active) begin
      case (ctrl.word.wb)
        mecodo_pkg::WB_PX: acc_x_r <= pos_sat;
        mecodo_pkg::WB_PY: acc_y_r <= pos_sat;
        mecodo_pkg::WB_DONE: begin
          if (!hold) begin
            acc_h_r <= head_fin;
          end
        end
        default: ;
      endcase
    end
  end

  // working registers of the datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sx_r <= fl + rr - fr - rl;
      sy_r <= fr + fl + rr + rl;
      sw_r <= fr + rr - fl - rl;
    end
    if (ctrl.active) begin
      prod_r <= mul_p;
      case (ctrl.word.wb)
        mecodo_pkg::WB_VX:   vx_r  <= vel_sat;
        mecodo_pkg::WB_VY:   vy_r  <= vel_sat;
        mecodo_pkg::WB_WZ:   wz_r  <= yaw_sat;
        mecodo_pkg::WB_HEAD: rem_r <= head_sum[REM_W-1:0];
        mecodo_pkg::WB_MOD: begin
          if (rem_r >= mod_sub) begin
            rem_r <= rem_r - mod_sub;
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= {head_fin, acc_y_r, acc_x_r, wz_r, vy_r, vx_r};
    end
  end

  // a result appears only from the final program step
  a_valid_from_fire: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(fire))
    else $error("result item raised without a finished program");

  // the heading reduction is complete when the program ends
  a_rem_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> (rem_r < REM_W'(mecodo_pkg::HEAD_TWO_PI)))
    else $error("heading remainder not reduced at program end");

  // stored heading stays within one turn
  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_h_r >= -16'sd25736) && (acc_h_r <= 16'sd25735))
    else $error("stored heading outside of [-pi, pi)");

endmodule

>>> hdl/mecodo_seq.sv
// ----------------------------------------------------------------------------
// mecodo_seq: microcode sequencer
// Step counter over the microprogram, a loop counter for the heading
// reduction and a hold on the final step while the result is not taken.
// ----------------------------------------------------------------------------
module mecodo_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  hold,
  output mecodo_pkg::seq_ctrl_t ctrl
);

  logic                              busy_r, busy_nxt;
  logic [mecodo_pkg::PC_W-1:0]       pc_r, pc_nxt;
  logic [mecodo_pkg::LOOP_W-1:0]     loop_r, loop_nxt;
  mecodo_pkg::ucode_t                word;

  // control word of the current step
  assign word = mecodo_pkg::micro_rom(pc_r);

  assign ctrl.active   = busy_r;
  assign ctrl.word     = word;
  assign ctrl.loop_cnt = loop_r;

  // next step
  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    loop_nxt = loop_r;
    if (start) begin
      busy_nxt = 1'b1;
      pc_nxt   = '0;
    end else if (busy_r) begin
      if (word.load_loop) begin
        loop_nxt = mecodo_pkg::LOOP_W'(mecodo_pkg::MOD_STEPS - 1);
      end
      unique case (word.jmp)
        mecodo_pkg::JMP_NEXT: pc_nxt = pc_r + 1'b1;
        mecodo_pkg::JMP_LOOP: begin
          if (loop_r != '0) begin
            loop_nxt = loop_r - 1'b1;
          end else begin
            pc_nxt = pc_r + 1'b1;
          end
        end
        mecodo_pkg::JMP_END: begin
          if (!hold) begin
            busy_nxt = 1'b0;
            pc_nxt   = '0;
          end
        end
        default: pc_nxt = '0;
      endcase
    end
  end

  // step counter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= '0;
      loop_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
      loop_r <= loop_nxt;
    end
  end

endmodule

>>> tb/mecanum_odometry_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mecanum_odometry_unit_test: self-checking bench for the odometry unit
// Streams wheel speed items through the unit under random source and sink
// gaps, predicts velocities and pose per item in a bit-true integrator of its
// own, and compares every result field by field. A directed table of edge
// cases (extreme speeds, saturation, zero gains, heading wrap at pi) comes
// first, then random phases under a series of gain and period settings.
// ----------------------------------------------------------------------------
module mecanum_odometry_unit_test;

  localparam int N_DIRECTED  = 26;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_LIMIT = 5000;
  localparam int HOLD_AT     = 60;     // results seen before the long sink hold-off
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_PRINTS  = 40;

  // register index that decodes to nothing
  localparam logic [1:0] REG_SPARE = 2'd3;

  localparam longint VEL_MIN = -64'sd32768;
  localparam longint VEL_MAX = 64'sd32767;
  localparam longint POS_MIN = -64'sd2147483648;
  localparam longint POS_MAX = 64'sd2147483647;

  // in_tdata layout, lowest bits first: fr, fl, rr, rl
  typedef struct packed {
    logic signed [15:0] rl;
    logic signed [15:0] rr;
    logic signed [15:0] fl;
    logic signed [15:0] fr;
  } wheel_set_t;

  // out_tdata layout, lowest bits first: vel_x, vel_y, yaw_rate, pos_x, pos_y, heading
  typedef struct packed {
    logic signed [15:0] heading;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_x;
    logic signed [15:0] yaw_rate;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_x;
  } odo_result_t;

  typedef enum {ROW_TICK, ROW_CFG} row_kind_t;
  typedef enum {MIX_CRUISE, MIX_NOISE, MIX_DRIFT} mix_t;

  // one directed row: a wheel item, or a new set of gains and period
  typedef struct {
    row_kind_t kind;
    int        fr, fl, rr, rl;
    bit        clr;
    int        lin, rot, period;
    bit        typed;
    int        want_vx, want_vy, want_wz, want_px, want_py, want_hd;
  } stim_row_t;

  logic                                 clk       = 1'b0;
  logic                                 rst_n     = 1'b0;
  logic                                 in_tvalid = 1'b0;
  logic                                 in_tready;
  logic [mecodo_pkg::IN_DATA_W-1:0]     in_tdata  = '0;
  logic                                 in_tuser  = 1'b0;
  logic                                 out_tvalid;
  logic                                 out_tready = 1'b0;
  logic [mecodo_pkg::OUT_DATA_W-1:0]    out_tdata;
  logic                                 cfg_we    = 1'b0;
  logic [1:0]                           cfg_addr  = '0;
  logic [15:0]                          cfg_wdata = '0;

  // integrator copy of the gains and the pose
  logic [15:0]        lin_gain = mecodo_pkg::LIN_RESET;
  logic [15:0]        rot_gain = mecodo_pkg::ROT_RESET;
  logic [15:0]        tick_len = mecodo_pkg::TICK_RESET;
  int                 pose_x   = 0;
  int                 pose_y   = 0;
  logic signed [15:0] pose_hd  = '0;

  odo_result_t pose_expected[$];
  int          error_count  = 0;
  int          results_seen = 0;
  int          cycle_count  = 0;
  bit          steady_flow  = 1'b0;
  stim_row_t   directed_rows [N_DIRECTED];

  mecanum_odometry_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_error(input string msg);
    if (error_count < MAX_PRINTS) begin
      $display("ERROR %0t: %s", $time, msg);
    end
    error_count++;
  endtask

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want) begin
      report_error($sformatf("result %0d %s: got %0d, expected %0d",
                             results_seen, name, got, want));
    end
  endtask

  // shift right rounding half up, i.e. floor of (v + half) / 2^s
  function automatic longint round_shr(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // kinematics and pose update for one tick, advances the pose copy
  function automatic odo_result_t integrate_tick(input wheel_set_t w, input bit clr);
    longint      fr, fl, rr, rl, sx, sy, sw, vx, vy, wz;
    longint      lin, rot, tp, nx, ny, nh, r;
    odo_result_t res;
    fr  = longint'(w.fr);
    fl  = longint'(w.fl);
    rr  = longint'(w.rr);
    rl  = longint'(w.rl);
    lin = longint'(lin_gain);
    rot = longint'(rot_gain);
    tp  = longint'(tick_len);
    sx  = -fr + fl + rr - rl;
    sy  = fr + fl + rr + rl;
    sw  = fr - fl + rr - rl;
    vx  = clip(round_shr(sx * lin, 16), VEL_MIN, VEL_MAX);
    vy  = clip(round_shr(sy * lin, 16), VEL_MIN, VEL_MAX);
    wz  = clip(round_shr(sw * rot, 12), VEL_MIN, VEL_MAX);
    if (clr) begin
      pose_x  = 0;
      pose_y  = 0;
      pose_hd = '0;
    end
    nx = longint'(pose_x) + round_shr(vx * tp, 8);
    ny = longint'(pose_y) + round_shr(vy * tp, 8);
    nh = longint'(pose_hd) + round_shr(wz * tp, 11);
    pose_x = int'(clip(nx, POS_MIN, POS_MAX));
    pose_y = int'(clip(ny, POS_MIN, POS_MAX));
    // heading wraps by a full turn into [-pi, pi)
    r = (nh + longint'(mecodo_pkg::HEAD_PI)) % longint'(mecodo_pkg::HEAD_TWO_PI);
    if (r < 0) r += longint'(mecodo_pkg::HEAD_TWO_PI);
    pose_hd = 16'(r - longint'(mecodo_pkg::HEAD_PI));
    res.vel_x    = vx[15:0];
    res.vel_y    = vy[15:0];
    res.yaw_rate = wz[15:0];
    res.pos_x    = pose_x;
    res.pos_y    = pose_y;
    res.heading  = pose_hd;
    return res;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (steady_flow) return 0;
    r = int'($urandom_range(0, 99));
    if (r < 50) return 0;
    if (r < 85) return int'($urandom_range(1, 3));
    if (r < 97) return int'($urandom_range(4, 12));
    return int'($urandom_range(20, 60));
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      mecodo_pkg::REG_LIN:  lin_gain = val;
      mecodo_pkg::REG_ROT:  rot_gain = val;
      mecodo_pkg::REG_TICK: tick_len = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // all three registers, plus a write to the unused index that must change nothing
  task automatic apply_settings(input logic [15:0] lin, input logic [15:0] rot,
                                input logic [15:0] period);
    write_reg(mecodo_pkg::REG_LIN, lin);
    write_reg(mecodo_pkg::REG_ROT, rot);
    write_reg(mecodo_pkg::REG_TICK, period);
    write_reg(REG_SPARE, 16'($urandom_range(0, 65535)));
  endtask

  // stop offering and wait for every pending result
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pose_expected.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic send_tick(input wheel_set_t w, input bit clr, input bit typed,
                           input odo_result_t typed_want);
    int          gap;
    odo_result_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    in_tuser  <= clr;
    do @(posedge clk); while (in_tready !== 1'b1);
    predicted = integrate_tick(w, clr);
    pose_expected.push_back(typed ? typed_want : predicted);
  endtask

  // one random phase under fixed settings
  task automatic run_phase(input logic [15:0] lin, input logic [15:0] rot,
                           input logic [15:0] period, input mix_t mix, input int count);
    wheel_set_t w;
    bit         clr;
    int         fwd, strafe, turn, half, k, a, b;
    settle();
    apply_settings(lin, rot, period);
    fwd    = 0;
    strafe = 0;
    turn   = 0;
    half   = count / 2;
    for (k = 0; k < count; k++) begin
      clr = 1'b0;
      case (mix)
        MIX_CRUISE: begin
          // steady motion commands mapped to wheels, a little noise, rare clears
          if ($urandom_range(0, 19) == 0) begin
            fwd    = int'($urandom_range(0, 4000)) - 2000;
            strafe = int'($urandom_range(0, 4000)) - 2000;
            turn   = int'($urandom_range(0, 2000)) - 1000;
          end
          w.fr = 16'(fwd - strafe + turn + int'($urandom_range(0, 40)) - 20);
          w.fl = 16'(fwd + strafe - turn + int'($urandom_range(0, 40)) - 20);
          w.rr = 16'(fwd + strafe + turn + int'($urandom_range(0, 40)) - 20);
          w.rl = 16'(fwd - strafe - turn + int'($urandom_range(0, 40)) - 20);
          clr  = ($urandom_range(0, 49) == 0);
          if ($urandom_range(0, 9) == 0) begin
            w = {$urandom(), $urandom()};
          end
        end
        MIX_NOISE: begin
          w   = {$urandom(), $urandom()};
          clr = 1'($urandom_range(0, 1));
        end
        default: begin
          // diagonal drive hard enough to saturate both velocities, up then down
          a = int'($urandom_range(24000, 32767));
          b = int'($urandom_range(24000, 32767));
          if (k >= half) begin
            a = -a - 1;
            b = -b - 1;
          end
          w.fl = 16'(a);
          w.rr = 16'(b);
          w.fr = 16'(int'($urandom_range(0, 4000)) - 2000);
          w.rl = 16'(int'($urandom_range(0, 4000)) - 2000);
          clr  = (k == 0) || (k == half);
        end
      endcase
      send_tick(w, clr, 1'b0, '0);
    end
  endtask

  // result sink: random back-pressure, one long hold-off, checks
  initial begin : result_sink
    int          stall_left;
    int          hold_left;
    int          g;
    bit          held;
    odo_result_t got;
    odo_result_t want;
    stall_left = 0;
    hold_left  = 0;
    held       = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid === 1'b1 && out_tready) begin
        got = odo_result_t'(out_tdata);
        if (pose_expected.size() == 0) begin
          report_error("result arrived with no tick pending");
        end else begin
          want = pose_expected.pop_front();
          check_field("vel_x", got.vel_x, want.vel_x);
          check_field("vel_y", got.vel_y, want.vel_y);
          check_field("yaw_rate", got.yaw_rate, want.yaw_rate);
          check_field("pos_x", got.pos_x, want.pos_x);
          check_field("pos_y", got.pos_y, want.pos_y);
          check_field("heading", got.heading, want.heading);
          results_seen++;
        end
      end
      if (!held && results_seen == HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (steady_flow) begin
        out_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        g = pick_gap();
        if (g > 0) begin
          stall_left = g - 1;
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
        end
      end
    end
  end

  // watchdog
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** mecanum_odometry_unit: FAILED **");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    stim_row_t   row;
    wheel_set_t  w;
    odo_result_t want;
    int          drain;

    directed_rows = '{
      // after reset: at rest, straight ahead, one wheel alone
      '{kind: ROW_TICK, typed: 1, default: 0},
      '{kind: ROW_TICK, fr: 256, fl: 256, rr: 256, rl: 256, default: 0},
      '{kind: ROW_TICK, fr: 256, default: 0},
      // pure strafe, pure rotation
      '{kind: ROW_TICK, fr: -256, fl: 256, rr: 256, rl: -256, default: 0},
      '{kind: ROW_TICK, fr: 256, fl: -256, rr: 256, rl: -256, default: 0},
      // speed extremes
      '{kind: ROW_TICK, fr: 32767, fl: 32767, rr: 32767, rl: 32767, default: 0},
      '{kind: ROW_TICK, fr: -32768, fl: -32768, rr: -32768, rl: -32768, default: 0},
      '{kind: ROW_TICK, fr: 32767, fl: -32768, rr: 32767, rl: -32768, default: 0},
      '{kind: ROW_TICK, fr: -32768, fl: 32767, rr: -32768, rl: 32767, default: 0},
      // clear brings the pose back to zero
      '{kind: ROW_TICK, clr: 1, typed: 1, default: 0},
      // largest gains and period: velocity saturation
      '{kind: ROW_CFG, lin: 65535, rot: 65535, period: 65535, default: 0},
      '{kind: ROW_TICK, fr: 32767, fl: 32767, rr: 32767, rl: 32767, clr: 1, default: 0},
      '{kind: ROW_TICK, fr: 32767, fl: -32768, rr: 32767, rl: -32768, default: 0},
      '{kind: ROW_TICK, fr: -32768, fl: 32767, rr: 32767, rl: -32768, default: 0},
      '{kind: ROW_TICK, fr: 32767, fl: -32768, rr: -32768, rl: 32767, default: 0},
      '{kind: ROW_TICK, fr: -32768, fl: -32768, rr: -32768, rl: -32768, default: 0},
      // zero gains and period give no motion at all
      '{kind: ROW_CFG, default: 0},
      '{kind: ROW_TICK, fr: 32767, fl: -32768, rr: 32767, rl: -32768, clr: 1, typed: 1,
        default: 0},
      // unit yaw gain, increment equal to yaw rate: heading wrap around pi
      '{kind: ROW_CFG, lin: 0, rot: 4096, period: 2048, default: 0},
      '{kind: ROW_TICK, fr: 12868, rr: 12868, clr: 1, typed: 1, want_wz: 25736,
        want_hd: -25736, default: 0},
      '{kind: ROW_TICK, fr: -12868, rr: -12868, typed: 1, want_wz: -25736, default: 0},
      '{kind: ROW_TICK, fr: 12867, rr: 12868, typed: 1, want_wz: 25735, want_hd: 25735,
        default: 0},
      '{kind: ROW_TICK, fr: 1, typed: 1, want_wz: 1, want_hd: -25736, default: 0},
      '{kind: ROW_TICK, fr: -1, typed: 1, want_wz: -1, want_hd: 25735, default: 0},
      // back to the reset settings
      '{kind: ROW_CFG, lin: 1638, rot: 2048, period: 655, default: 0},
      '{kind: ROW_TICK, fr: -32768, fl: -32768, rr: 32767, rl: 32767, clr: 1, default: 0}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) begin
        settle();
        apply_settings(16'(row.lin), 16'(row.rot), 16'(row.period));
      end else begin
        w.fr = 16'(row.fr);
        w.fl = 16'(row.fl);
        w.rr = 16'(row.rr);
        w.rl = 16'(row.rl);
        want.vel_x    = 16'(row.want_vx);
        want.vel_y    = 16'(row.want_vy);
        want.yaw_rate = 16'(row.want_wz);
        want.pos_x    = row.want_px;
        want.pos_y    = row.want_py;
        want.heading  = 16'(row.want_hd);
        send_tick(w, row.clr, row.typed, want);
      end
    end

    // random phases
    run_phase(mecodo_pkg::LIN_RESET, mecodo_pkg::ROT_RESET, mecodo_pkg::TICK_RESET,
              MIX_CRUISE, 90);
    run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)), MIX_NOISE, 90);
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, MIX_DRIFT, 540);
    steady_flow = 1'b1;
    run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)), MIX_CRUISE, 90);
    steady_flow = 1'b0;
    run_phase(16'h0000, 16'hFFFF, 16'($urandom_range(0, 65535)), MIX_NOISE, 90);
    run_phase(16'hFFFF, 16'h0000, 16'h0000, MIX_CRUISE, 90);
    run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)), MIX_CRUISE, 90);
    run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)), MIX_NOISE, 90);
    run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              16'hFFFF, MIX_CRUISE, 90);
    run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)), MIX_NOISE, 90);
    run_phase(mecodo_pkg::LIN_RESET, mecodo_pkg::ROT_RESET, mecodo_pkg::TICK_RESET,
              MIX_CRUISE, 90);

    // drain, then wait on for anything stray
    in_tvalid <= 1'b0;
    drain = 0;
    while (pose_expected.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (20) @(posedge clk);
    if (pose_expected.size() != 0) begin
      report_error($sformatf("%0d results never arrived", pose_expected.size()));
    end

    if (error_count == 0) begin
      $display("** mecanum_odometry_unit: PASSED **");
    end else begin
      $display("** mecanum_odometry_unit: FAILED **");
    end
    $finish;
  end

endmodule

>>> mecanum_odometry_unit.f
hdl/mecodo_pkg.sv
hdl/mecodo_seq.sv
hdl/mecanum_odometry_unit.sv
tb/mecanum_odometry_unit_test.sv
